[rtl/sfd_pkg.sv]
// Shared constants, types and the CRC-16/Modbus byte update for the deframer.
// No dependencies; all modules import it.
package sfd_pkg;

    localparam logic [7:0]  HEAD_BYTE = 8'hAA;
    localparam logic [7:0]  TAIL_BYTE = 8'h55;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam int          CNT_W     = 17;
    localparam logic [CNT_W-1:0] MIN_BODY_LEN = 17'd8;
    localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT   = 2'd1;
    localparam logic [15:0]      PAYLOAD_LIMIT_RST = 16'd1024;
    localparam logic [CNT_W-1:0] FRAME_LIMIT_RST   = 17'd2068;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_LEN_BAD   = 3'd2,
        ST_CRC_BAD   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_RESTARTED = 3'd5
    } t_status;

    // Per-frame body state updated by the body unit.
    typedef struct packed {
        logic [CNT_W-1:0] body_count;
        logic [15:0]      crc_running;
        logic [15:0]      crc_received;
        logic [3:0][7:0]  hdr;
        logic [15:0]      length;
    } t_body_state;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_START = crc16_byte(CRC_INIT, HEAD_BYTE);

endpackage

[rtl/sfd_rx_if.sv]
// Input channel: one raw wire byte per word, valid/ready handshake.
// Depends on nothing but the handshake convention.
interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/sfd_res_if.sv]
// Result channel: payload bytes and end-of-frame status words.
// Depends on nothing but the handshake convention.
interface sfd_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  address;
    logic [7:0]  sequence_res;
    logic [7:0]  frame_type;
    logic [7:0]  command;
    logic [15:0] payload_length;
    logic [2:0]  status;

    modport source (output valid, output kind, output data_byte, output address,
                    output sequence_res, output frame_type, output command,
                    output payload_length, output status, input ready);
    modport sink   (input valid, input kind, input data_byte, input address,
                    input sequence_res, input frame_type, input command,
                    input payload_length, input status, output ready);
endinterface

[rtl/sfd_body_unit.sv]
// Applies one unstuffed body byte: header/length capture, CRC, received CRC.
// Depends on sfd_pkg.
module sfd_body_unit
    import sfd_pkg::*;
(
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  t_body_state i_cur,
    output t_body_state o_nxt,
    output logic        o_payload
);

    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] crc_lo_idx;
    logic [CNT_W-1:0] crc_hi_idx;
    logic [15:0]      crc_upd;

    assign idx        = i_cur.body_count;
    assign crc_lo_idx = CNT_W'(i_cur.length) + CNT_W'(6);
    assign crc_hi_idx = CNT_W'(i_cur.length) + CNT_W'(7);
    assign crc_upd    = crc16_byte(i_cur.crc_running, i_byte);

    always_comb begin
        o_nxt     = i_cur;
        o_payload = 1'b0;
        if (i_en) begin
            if (idx < CNT_W'(4)) begin
                o_nxt.hdr[idx[1:0]] = i_byte;
                o_nxt.crc_running   = crc_upd;
            end else if (idx == CNT_W'(4)) begin
                o_nxt.length      = {8'h00, i_byte};
                o_nxt.crc_running = crc_upd;
            end else if (idx == CNT_W'(5)) begin
                o_nxt.length      = {i_byte, i_cur.length[7:0]};
                o_nxt.crc_running = crc_upd;
            end else if (idx < crc_lo_idx) begin
                o_nxt.crc_running = crc_upd;
                o_payload         = 1'b1;
            end else if (idx == crc_lo_idx) begin
                o_nxt.crc_received[7:0] = i_byte;
            end else if (idx == crc_hi_idx) begin
                o_nxt.crc_received[15:8] = i_byte;
            end
            // saturate so a runaway body cannot wrap back to a short count
            if (idx != COUNT_MAX) begin
                o_nxt.body_count = idx + CNT_W'(1);
            end
        end
    end

endmodule

[rtl/stuffed_frame_deframer_unit.sv]
// Byte-stuffed frame deframer with CRC-16/Modbus check, streaming payload out.
// Depends on sfd_pkg, sfd_rx_if, sfd_res_if and sfd_body_unit.
// An accepted word is held in the input register; its result (if any) goes to the result register.
// Throughput: one wire byte per cycle unless the result sink stalls; an input register and a result register
//   bound the single pass of unstuffing, one CRC byte update and the tail checks.
// Reset: synchronous active-low; hunt for a head, limits back to 1024 and 2068.
module stuffed_frame_deframer_unit
    import sfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfd_rx_if.sink                i_rx,
    sfd_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [15:0]      r_payload_limit;
    logic [CNT_W-1:0] r_frame_limit;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // frame state
    logic             r_in_frame, n_in_frame;
    logic             r_esc,      n_esc;
    logic [CNT_W-1:0] r_raw_count, n_raw_count;
    t_body_state      r_body,     n_body;

    // result register
    logic        r_out_valid;
    logic        r_out_kind;
    logic [7:0]  r_out_data;
    logic [3:0][7:0] r_out_hdr;
    logic [15:0] r_out_len;
    t_status     r_out_status;

    // single-pass results
    logic        produce;
    logic        res_kind;
    logic [7:0]  res_data;
    logic [3:0][7:0] res_hdr;
    logic [15:0] res_len;
    t_status     res_status;

    logic        advance;
    logic        body_en;
    logic [7:0]  body_byte;
    t_body_state body_nxt;
    logic        body_payload;
    logic        is_head, is_tail;
    logic [CNT_W-1:0] raw_inc;
    t_body_state start_state;

    // Take a new word whenever the input register drains this cycle.
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    assign is_head = (r_in_byte == HEAD_BYTE);
    assign is_tail = (r_in_byte == TAIL_BYTE);

    // A tail after an escape flushes the escape byte as a literal body byte;
    // an escape byte that is not itself escaped only arms the flag.
    always_comb begin
        if (is_tail) begin
            body_byte = ESC_BYTE;
            body_en   = r_in_frame && r_esc;
        end else if (r_esc) begin
            body_byte = r_in_byte ^ ESC_XOR;
            body_en   = r_in_frame && !is_head;
        end else begin
            body_byte = r_in_byte;
            body_en   = r_in_frame && !is_head && (r_in_byte != ESC_BYTE);
        end
    end

    sfd_body_unit u_body (
        .i_en      (body_en),
        .i_byte    (body_byte),
        .i_cur     (r_body),
        .o_nxt     (body_nxt),
        .o_payload (body_payload)
    );

    assign raw_inc = (r_raw_count == COUNT_MAX) ? COUNT_MAX : r_raw_count + CNT_W'(1);

    always_comb begin
        start_state              = '0;
        start_state.crc_running  = CRC_START;
    end

    // Decide the next frame state and the result of the word in the input register.
    always_comb begin
        n_in_frame  = r_in_frame;
        n_esc       = r_esc;
        n_raw_count = r_raw_count;
        n_body      = r_body;
        produce     = 1'b0;
        res_kind    = KIND_END;
        res_data    = 8'h00;
        res_hdr     = body_nxt.hdr;
        res_len     = body_nxt.length;
        res_status  = ST_OK;

        if (!r_in_frame) begin
            // hunting: drop everything but a head
            if (is_head) begin
                n_in_frame  = 1'b1;
                n_esc       = 1'b0;
                n_raw_count = CNT_W'(1);
                n_body      = start_state;
            end
        end else if (is_head) begin
            // restart: report the abandoned frame with its old fields
            produce     = 1'b1;
            res_hdr     = r_body.hdr;
            res_len     = r_body.length;
            res_status  = ST_RESTARTED;
            n_esc       = 1'b0;
            n_raw_count = CNT_W'(1);
            n_body      = start_state;
        end else if (is_tail) begin
            produce    = 1'b1;
            n_body     = body_nxt;
            n_in_frame = 1'b0;
            n_esc      = 1'b0;
            if (body_nxt.body_count < MIN_BODY_LEN) begin
                res_status = ST_SHORT;
            end else if ((body_nxt.length > r_payload_limit) ||
                         (body_nxt.body_count != CNT_W'(body_nxt.length) + MIN_BODY_LEN)) begin
                res_status = ST_LEN_BAD;
            end else if (body_nxt.crc_running != body_nxt.crc_received) begin
                res_status = ST_CRC_BAD;
            end
        end else begin
            n_raw_count = raw_inc;
            n_body      = body_nxt;
            n_esc       = !r_esc && (r_in_byte == ESC_BYTE);
            if (raw_inc > r_frame_limit) begin
                // overflow wins over a payload byte on the same word
                produce    = 1'b1;
                res_status = ST_OVERFLOW;
                n_in_frame = 1'b0;
                n_esc      = 1'b0;
            end else if (body_payload) begin
                produce  = 1'b1;
                res_kind = KIND_PAYLOAD;
                res_data = body_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_limit <= PAYLOAD_LIMIT_RST;
            r_frame_limit   <= FRAME_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PAYLOAD_LIMIT) begin
                r_payload_limit <= i_cfg_data[15:0];
            end else if (i_cfg_idx == CFG_FRAME_LIMIT) begin
                r_frame_limit <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // Input register: load on accept, drop when consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Frame state: advance once per consumed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_esc       <= 1'b0;
            r_raw_count <= '0;
            r_body      <= start_state;
        end else if (advance) begin
            r_in_frame  <= n_in_frame;
            r_esc       <= n_esc;
            r_raw_count <= n_raw_count;
            r_body      <= n_body;
        end
    end

    // Result register: hold until taken by the sink.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= produce;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && produce) begin
            r_out_kind   <= res_kind;
            r_out_data   <= res_data;
            r_out_hdr    <= res_hdr;
            r_out_len    <= res_len;
            r_out_status <= res_status;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out_kind;
    assign o_res.data_byte      = r_out_data;
    assign o_res.address        = r_out_hdr[0];
    assign o_res.sequence_res   = r_out_hdr[1];
    assign o_res.frame_type     = r_out_hdr[2];
    assign o_res.command        = r_out_hdr[3];
    assign o_res.payload_length = r_out_len;
    assign o_res.status         = r_out_status;

`ifndef SYNTHESIS
    a_adv_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid == $past(produce)))
        else $error("result register does not follow the consumed word");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PAYLOAD) |-> (r_out_status == ST_OK))
        else $error("payload word carries a nonzero status");

    a_end_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_END) |-> (r_out_data == 8'h00))
        else $error("end word carries data");

    a_esc_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> r_in_frame)
        else $error("escape pending while hunting");

    a_hunt_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && produce && res_kind == KIND_END && res_status != ST_RESTARTED)
        |=> !r_in_frame)
        else $error("frame still open after a closing end word");
`endif

endmodule
